>>> src/ridt_pkg.sv
// ============================================================================
// ridt_pkg
// Types, constants and state codes shared by the ring dedup table modules.
// ============================================================================
package ridt_pkg;

    localparam int RING_SIZE   = 6;
    localparam int MAX_BUCKETS = 1024;
    localparam int CAPACITY    = 4096;
    localparam int VAL_W       = 24;
    localparam int BKT_W       = $clog2(MAX_BUCKETS);
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int CFG_W       = 11;
    localparam int SUM_W       = VAL_W + $clog2(RING_SIZE) + 1;
    localparam int POS_W       = $clog2(RING_SIZE);

    typedef struct packed {
        logic [VAL_W-1:0] arm_5;
        logic [VAL_W-1:0] arm_4;
        logic [VAL_W-1:0] arm_3;
        logic [VAL_W-1:0] arm_2;
        logic [VAL_W-1:0] arm_1;
        logic [VAL_W-1:0] arm_0;
    } in_item_t;

    typedef struct packed {
        logic duplicate;
        logic added;
        logic store_full;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_HEAD,
        ST_READ,
        ST_CMP,
        ST_WRITE,
        ST_DONE,
        ST_CLEAR
    } state_t;

    // Control between sequencer and modulo unit
    typedef struct packed {
        logic start;
    } mod_ctrl_t;

    typedef struct packed {
        logic             done;
        logic [BKT_W-1:0] rem;
    } mod_stat_t;

endpackage

>>> src/rotation_invariant_dedup_table.sv
// ============================================================================
// rotation_invariant_dedup_table
// Duplicate detector for six-value rings, equal under rotation and reflection.
// ============================================================================
// Input channel: in_valid/in_stall carry one ring (in_data). Output channel:
// out_valid/out_stall carry one result (out_data) with exactly one of
// duplicate, added or store_full set. A transfer happens when valid is high
// and stall is low. bucket_count is to be written with cfg_we/cfg_data only
// while idle; the block itself does not enforce this. One ring is processed
// at a time; the block stalls its input meanwhile. Per ring: a bit-serial
// modulo of the hash over the bits of the 28-bit sum and a finishing step,
// a bucket head read, then per chain entry walked an entry memory read and
// a compare. A match presents the result next; otherwise a READ state ends
// the walk (skipped for an empty bucket), a WRITE state pushes, and the
// result follows. At reset a clearing pass marks all 1024 bucket heads empty
// and the input stalls meanwhile; the fill count is zero and bucket_count
// returns to 1024. While the receiver stalls the result is held and no new
// ring is taken.
// ============================================================================
module rotation_invariant_dedup_table
    import ridt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int RW = RING_SIZE * VAL_W;

    state_t state_reg, state_next;
    logic [CFG_W-1:0] bcount_reg;
    logic [RW-1:0]    ring_reg;
    logic [BKT_W-1:0] hash_reg;
    logic [BKT_W-1:0] clr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             cur_v_reg;
    logic [IDX_W-1:0] cur_idx_reg;
    logic [CNT_W-1:0] steps_reg;
    out_item_t        res_reg;

    logic [IDX_W:0]         head_mem [MAX_BUCKETS];
    logic [RW-1:0]          val_mem  [CAPACITY];
    logic [IDX_W:0]         next_mem [CAPACITY];

    logic [IDX_W:0]   head_rd;
    logic [RW-1:0]    val_rd;
    logic [IDX_W:0]   next_rd;

    logic [SUM_W-1:0] in_sum;
    logic [BKT_W-1:0] head_ra;
    logic             head_we;
    logic [BKT_W-1:0] head_wa;
    logic [IDX_W:0]   head_wd;

    logic [CFG_W-1:0] divisor;
    mod_ctrl_t        mctl;
    mod_stat_t        mst;
    logic             match;
    logic             take;

    assign take = in_valid && !in_stall;

    always_comb
    begin
        divisor = bcount_reg;
        if (bcount_reg == '0)
            divisor = CFG_W'(1);
        else if (bcount_reg > CFG_W'(MAX_BUCKETS))
            divisor = CFG_W'(MAX_BUCKETS);
    end

    ridt_mod_unit u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mctl),
        .sum     (in_sum),
        .divisor (divisor),
        .stat    (mst)
    );

    ridt_ring_cmp u_cmp (
        .stored (val_rd),
        .ring   (ring_reg),
        .match  (match)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == BKT_W'(MAX_BUCKETS - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (in_valid) state_next = ST_HASH;
            ST_HASH:  if (mst.done) state_next = ST_HEAD;
            ST_HEAD:
            begin
                if (head_rd[IDX_W]) state_next = ST_READ;
                else                state_next = ST_WRITE;
            end
            ST_READ:
            begin
                if (cur_v_reg && steps_reg < CNT_W'(CAPACITY)) state_next = ST_CMP;
                else                                          state_next = ST_WRITE;
            end
            ST_CMP:
            begin
                if (match) state_next = ST_DONE;
                else       state_next = ST_READ;
            end
            ST_WRITE: state_next = ST_DONE;
            ST_DONE:  if (!out_stall) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall   = (state_reg != ST_IDLE);
        out_valid  = (state_reg == ST_DONE);
        out_data   = res_reg;
        mctl.start = take;
    end

    // Bucket head port: read the new hash as it lands, write empty heads while clearing and the new head on a push
    always_comb
    begin
        in_sum  = SUM_W'(in_data.arm_0) + SUM_W'(in_data.arm_1) + SUM_W'(in_data.arm_2)
                + SUM_W'(in_data.arm_3) + SUM_W'(in_data.arm_4) + SUM_W'(in_data.arm_5);
        head_ra = mst.done ? mst.rem : hash_reg;
        head_we = 1'b0;
        head_wa = hash_reg;
        head_wd = {1'b1, fill_reg[IDX_W-1:0]};
        if (state_reg == ST_CLEAR)
        begin
            head_we = 1'b1;
            head_wa = clr_reg;
            head_wd = '0;
        end
        else if (state_reg == ST_WRITE && fill_reg < CNT_W'(CAPACITY))
            head_we = 1'b1;
    end

    // Memories: head index, entry values and links
    always_ff @(posedge clk)
    begin
        head_rd <= head_mem[head_ra];
        val_rd  <= val_mem[cur_idx_reg];
        next_rd <= next_mem[cur_idx_reg];
        if (head_we)
            head_mem[head_wa] <= head_wd;
        if (state_reg == ST_WRITE && fill_reg < CNT_W'(CAPACITY))
        begin
            val_mem[fill_reg[IDX_W-1:0]]  <= ring_reg;
            next_mem[fill_reg[IDX_W-1:0]] <= head_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            ring_reg <= in_data;
        if (mst.done)
            hash_reg <= mst.rem;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            bcount_reg  <= CFG_W'(1024);
            fill_reg    <= '0;
            cur_v_reg   <= 1'b0;
            cur_idx_reg <= '0;
            steps_reg   <= '0;
            res_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                bcount_reg <= cfg_data;
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                end
                ST_HEAD:
                begin
                    cur_v_reg   <= head_rd[IDX_W];
                    cur_idx_reg <= head_rd[IDX_W-1:0];
                    steps_reg   <= '0;
                end
                ST_CMP:
                begin
                    if (match)
                    begin
                        res_reg <= '{duplicate: 1'b1, added: 1'b0, store_full: 1'b0};
                    end
                    else
                    begin
                        // advance along the chain
                        cur_v_reg   <= next_rd[IDX_W];
                        cur_idx_reg <= next_rd[IDX_W-1:0];
                        steps_reg   <= steps_reg + 1'b1;
                    end
                end
                ST_WRITE:
                begin
                    if (fill_reg < CNT_W'(CAPACITY))
                    begin
                        fill_reg <= fill_reg + 1'b1;
                        res_reg  <= '{duplicate: 1'b0, added: 1'b1, store_full: 1'b0};
                    end
                    else
                    begin
                        res_reg <= '{duplicate: 1'b0, added: 1'b0, store_full: 1'b1};
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

>>> src/ridt_mod_unit.sv
// ============================================================================
// ridt_mod_unit
// Restoring remainder unit: sum modulo bucket count, one bit per cycle.
// ============================================================================
module ridt_mod_unit
    import ridt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  mod_ctrl_t        ctrl,
    input  logic [SUM_W-1:0] sum,
    input  logic [CFG_W-1:0] divisor,
    output mod_stat_t        stat
);

    localparam int BIT_W = $clog2(SUM_W + 1);
    localparam int REM_W = CFG_W + 1;

    logic [SUM_W-1:0] num_reg, num_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [BIT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [REM_W-1:0] shifted;

    always_comb
    begin
        shifted   = {rem_reg[REM_W-2:0], num_reg[SUM_W-1]};
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            num_next  = sum;
            rem_next  = '0;
            cnt_next  = BIT_W'(SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[SUM_W-2:0], 1'b0};
            if (shifted >= {1'b0, divisor})
                rem_next = shifted - {1'b0, divisor};
            else
                rem_next = shifted;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == BIT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign stat.done = done_reg;
    assign stat.rem  = rem_reg[BKT_W-1:0];

endmodule

>>> src/ridt_ring_cmp.sv
// ============================================================================
// ridt_ring_cmp
// Compares a stored ring with the input under all rotations and reflections.
// ============================================================================
module ridt_ring_cmp
    import ridt_pkg::*;
(
    input  logic [RING_SIZE*VAL_W-1:0] stored,
    input  logic [RING_SIZE*VAL_W-1:0] ring,
    output logic                       match
);

    always_comb
    begin
        logic cw;
        logic ccw;
        match = 1'b0;
        for (int off = 0; off < RING_SIZE; off++)
        begin
            cw  = 1'b1;
            ccw = 1'b1;
            for (int i = 0; i < RING_SIZE; i++)
            begin
                if (stored[i*VAL_W +: VAL_W] != ring[((off + i) % RING_SIZE)*VAL_W +: VAL_W])
                    cw = 1'b0;
                if (stored[i*VAL_W +: VAL_W]
                    != ring[((off + RING_SIZE - i) % RING_SIZE)*VAL_W +: VAL_W])
                    ccw = 1'b0;
            end
            if (cw || ccw)
                match = 1'b1;
        end
    end

endmodule
